/* sv/bounded_list_stack_queue_engine_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list stack/queue engine
// Implication checks that drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_STACK_QUEUE_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_STACK_QUEUE_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BLSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed (same cycle)");
`define BLSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed (next cycle)");
`else
`define BLSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BLSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/blsq_pkg.sv */
// ----------------------------------------------------------------------------
// blsq_pkg
// Widths, command and status codes and controller states of the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package blsq_pkg;

    localparam int unsigned DEPTH_DEF = 64;

    localparam int unsigned CMD_W     = 3;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned POS_IN_W  = 7;
    localparam int unsigned POS_OUT_W = 6;
    localparam int unsigned STAT_W    = 3;
    localparam int unsigned CNT_OUT_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE_LAST  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND         = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_INS_TAKE,
        S_INS_LINK,
        S_DEL_FREE,
        S_FIND
    } t_state;

endpackage

`default_nettype wire

/* sv/blsq_ram.sv */
// ----------------------------------------------------------------------------
// blsq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blsq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/bounded_list_stack_queue_engine_core.sv */
// Push front, pop front and push back give their result from the execute state.
// Insert after p walks to entry p, takes a free slot, then links it in; delete last
// walks to the next-to-last entry, then frees the tail. Find stops at a match or the end.
// One link is followed per cycle through the read port of the link RAM.
// A new item is taken the cycle after the previous result is registered.
// After reset a clearing pass over every entry chains the free list; no item is taken.
// ----------------------------------------------------------------------------
// bounded_list_stack_queue_engine_core
// Ordered list of signed values kept in a linked store with a free list.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_stack_queue_engine_core #(
    parameter int unsigned DEPTH = blsq_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [blsq_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic signed [blsq_pkg::VAL_W-1:0]     i_value_in,
    input  wire logic        [blsq_pkg::POS_IN_W-1:0]  i_position_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed      [blsq_pkg::VAL_W-1:0]     o_value_out,
    output logic             [blsq_pkg::POS_OUT_W-1:0] o_position_out,
    output logic             [blsq_pkg::STAT_W-1:0]    o_status,
    output logic             [blsq_pkg::CNT_OUT_W-1:0] o_count_out
);

    import blsq_pkg::*;

    `include "bounded_list_stack_queue_engine_core_macros.svh"

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > POS_IN_W) ? CW : POS_IN_W;

    t_state r_state, n_state;

    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [AW-1:0]       r_free, n_free;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_clr, n_clr;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [POS_IN_W-1:0] r_pos, n_pos;
    logic [AW-1:0]       r_cur, n_cur;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_nextp, n_nextp;
    logic [AW-1:0]       r_new, n_new;

    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_value_out;
    logic [POS_OUT_W-1:0] r_position_out;
    logic [STAT_W-1:0]    r_status;
    logic [CNT_OUT_W-1:0] r_count_out;

    logic             w_in_ready, w_in_acc, w_out_free;
    logic             w_full, w_empty, w_one, w_badpos, w_idx_zero, w_hit, w_last;
    logic             fin;
    logic [VAL_W-1:0] res_value;
    logic [AW-1:0]    res_pos;
    logic [STAT_W-1:0] res_status;

    logic          lk_we, lk_re;
    logic [AW-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic             vl_we, vl_re;
    logic [AW-1:0]    vl_waddr, vl_raddr;
    logic [VAL_W-1:0] vl_wdata, vl_rdata;

    blsq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    blsq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vl_we),
        .i_waddr (vl_waddr),
        .i_wdata (vl_wdata),
        .i_re    (vl_re),
        .i_raddr (vl_raddr),
        .o_rdata (vl_rdata)
    );

    assign w_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && w_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_full     = (r_count >= CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_one      = (r_count == CW'(1));
    assign w_badpos   = (r_pos == '0) || (CMPW'(r_pos) > CMPW'(r_count));
    assign w_idx_zero = (r_idx == '0);
    assign w_hit      = (vl_rdata == r_val);
    assign w_last     = ((CW'(r_idx) + CW'(1)) == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_INSERT_AFTER: begin
                        if (!w_full && !w_badpos) n_state = S_WALK;
                        else if (w_out_free)      n_state = S_IDLE;
                    end
                    CMD_DELETE_LAST: begin
                        if (w_empty) begin
                            if (w_out_free) n_state = S_IDLE;
                        end else if (w_one) begin
                            n_state = S_DEL_FREE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    CMD_FIND: begin
                        if (!w_empty)        n_state = S_FIND;
                        else if (w_out_free) n_state = S_IDLE;
                    end
                    default: begin
                        if (w_out_free) n_state = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                if (w_idx_zero) begin
                    n_state = (r_cmd == CMD_INSERT_AFTER) ? S_INS_TAKE : S_DEL_FREE;
                end
            end
            S_INS_TAKE: n_state = S_INS_LINK;
            S_INS_LINK, S_DEL_FREE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            S_FIND: begin
                if ((w_hit || w_last) && w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_free  = r_free;
        n_count = r_count;
        n_clr   = r_clr;
        n_cmd   = r_cmd;
        n_val   = r_val;
        n_pos   = r_pos;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_nextp = r_nextp;
        n_new   = r_new;

        fin        = 1'b0;
        res_value  = '0;
        res_pos    = '0;
        res_status = ST_OK;

        lk_we    = 1'b0;
        lk_waddr = r_free;
        lk_wdata = r_head;
        lk_re    = 1'b0;
        lk_raddr = r_head;
        vl_we    = 1'b0;
        vl_waddr = r_free;
        vl_wdata = r_val;
        vl_re    = 1'b0;
        vl_raddr = r_head;

        case (r_state)
            S_CLEAR: begin
                lk_we    = 1'b1;
                lk_waddr = r_clr;
                lk_wdata = (r_clr == AW'(DEPTH - 1)) ? '0 : r_clr + AW'(1);
                n_clr    = r_clr + AW'(1);
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd    = i_cmd;
                    n_val    = i_value_in;
                    n_pos    = i_position_in;
                    lk_re    = 1'b1;
                    lk_raddr = (i_cmd == CMD_PUSH_FRONT || i_cmd == CMD_PUSH_BACK) ?
                               r_free : r_head;
                    vl_re    = 1'b1;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        fin = 1'b1;
                        if (w_full) begin
                            res_status = ST_FULL;
                        end else if (w_out_free) begin
                            vl_we    = 1'b1;
                            lk_we    = 1'b1;
                            lk_waddr = r_free;
                            lk_wdata = r_head;
                            n_free   = lk_rdata;
                            n_head   = r_free;
                            if (w_empty) n_tail = r_free;
                            n_count  = r_count + CW'(1);
                        end
                    end
                    CMD_POP_FRONT: begin
                        fin = 1'b1;
                        if (w_empty) begin
                            res_status = ST_EMPTY;
                        end else begin
                            res_value = vl_rdata;
                            if (w_out_free) begin
                                lk_we    = 1'b1;
                                lk_waddr = r_head;
                                lk_wdata = r_free;
                                n_free   = r_head;
                                n_head   = w_one ? '0 : lk_rdata;
                                if (w_one) n_tail = '0;
                                n_count  = r_count - CW'(1);
                            end
                        end
                    end
                    CMD_PUSH_BACK: begin
                        fin = 1'b1;
                        if (w_full) begin
                            res_status = ST_FULL;
                        end else if (w_out_free) begin
                            vl_we    = 1'b1;
                            lk_we    = !w_empty;
                            lk_waddr = r_tail;
                            lk_wdata = r_free;
                            if (w_empty) n_head = r_free;
                            n_tail   = r_free;
                            n_free   = lk_rdata;
                            n_count  = r_count + CW'(1);
                        end
                    end
                    CMD_INSERT_AFTER: begin
                        if (w_full) begin
                            fin        = 1'b1;
                            res_status = ST_FULL;
                        end else if (w_badpos) begin
                            fin        = 1'b1;
                            res_status = ST_BADPOS;
                        end else begin
                            n_cur = r_head;
                            n_idx = AW'(r_pos - POS_IN_W'(1));
                        end
                    end
                    CMD_DELETE_LAST: begin
                        if (w_empty) begin
                            fin        = 1'b1;
                            res_status = ST_EMPTY;
                        end else begin
                            n_cur = r_head;
                            n_idx = AW'(r_count - CW'(2));
                        end
                    end
                    CMD_FIND: begin
                        if (w_empty) begin
                            fin        = 1'b1;
                            res_status = ST_NOTFOUND;
                        end else begin
                            n_idx = '0;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_WALK: begin
                if (w_idx_zero) begin
                    if (r_cmd == CMD_INSERT_AFTER) begin
                        n_nextp  = lk_rdata;
                        lk_re    = 1'b1;
                        lk_raddr = r_free;
                    end
                end else begin
                    n_cur    = lk_rdata;
                    n_idx    = r_idx - AW'(1);
                    lk_re    = 1'b1;
                    lk_raddr = lk_rdata;
                end
            end
            S_INS_TAKE: begin
                vl_we    = 1'b1;
                lk_we    = 1'b1;
                lk_waddr = r_free;
                lk_wdata = r_nextp;
                n_new    = r_free;
                n_free   = lk_rdata;
            end
            S_INS_LINK: begin
                fin = 1'b1;
                if (w_out_free) begin
                    lk_we    = 1'b1;
                    lk_waddr = r_cur;
                    lk_wdata = r_new;
                    if (CMPW'(r_pos) == CMPW'(r_count)) n_tail = r_new;
                    n_count  = r_count + CW'(1);
                end
            end
            S_DEL_FREE: begin
                fin = 1'b1;
                if (w_out_free) begin
                    lk_we    = 1'b1;
                    lk_waddr = r_tail;
                    lk_wdata = r_free;
                    n_free   = r_tail;
                    n_head   = w_one ? '0 : r_head;
                    n_tail   = w_one ? '0 : r_cur;
                    n_count  = r_count - CW'(1);
                end
            end
            S_FIND: begin
                if (w_hit) begin
                    fin     = 1'b1;
                    res_pos = r_idx;
                end else if (w_last) begin
                    fin        = 1'b1;
                    res_status = ST_NOTFOUND;
                end else begin
                    n_idx    = r_idx + AW'(1);
                    lk_re    = 1'b1;
                    lk_raddr = lk_rdata;
                    vl_re    = 1'b1;
                    vl_raddr = lk_rdata;
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= '0;
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_count <= n_count;
            r_clr   <= n_clr;
            if (fin && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_pos   <= n_pos;
        r_cur   <= n_cur;
        r_idx   <= n_idx;
        r_nextp <= n_nextp;
        r_new   <= n_new;
        if (fin && w_out_free) begin
            r_value_out    <= res_value;
            r_position_out <= POS_OUT_W'(res_pos);
            r_status       <= res_status;
            r_count_out    <= CNT_OUT_W'(n_count);
        end
    end

    assign o_in_ready     = w_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_value_out    = r_value_out;
    assign o_position_out = r_position_out;
    assign o_status       = r_status;
    assign o_count_out    = r_count_out;

    `BLSQ_ASSERT_IMP(a_empty_resets_ends, i_clk, i_rst_n,
        r_count == '0, r_head == '0 && r_tail == '0)
    `BLSQ_ASSERT_IMP(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `BLSQ_ASSERT_NXT(a_idle_holds_list, i_clk, i_rst_n, r_state == S_IDLE && !w_in_acc,
        $stable(r_count) && $stable(r_free) && $stable(r_head))

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded list stack/queue engine. A shadow copy
// of the linked store predicts status, count, popped value and find position
// for every accepted command; results are compared in order. Directed
// commands hit empty and bad-position cases, then weighted random traffic
// grows, shrinks and searches it under random back-pressure, bar one phase.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import blsq_pkg::*;

    localparam int unsigned LIST_DEPTH = DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED_SIX   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_SEVEN = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_OUT_W-1:0]    position;
        logic [STAT_W-1:0]       status;
        logic [CNT_OUT_W-1:0]    count;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_valid;
    logic out_ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value_in;
    logic [POS_IN_W-1:0]     position_in;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic signed [VAL_W-1:0] o_value_out;
    logic [POS_OUT_W-1:0]    o_position_out;
    logic [STAT_W-1:0]       o_status;
    logic [CNT_OUT_W-1:0]    o_count_out;

    logic [VAL_W-1:0] shadow_value [0:LIST_DEPTH-1];
    logic [5:0]       shadow_link  [0:LIST_DEPTH-1];
    logic [5:0]       shadow_head;
    logic [5:0]       shadow_tail;
    logic [5:0]       shadow_free;
    int               shadow_count;

    t_list_result pending_results [$];
    t_list_result got_result;
    t_list_result want_result;
    logic         steady_flow = 1'b0;
    int           mismatches  = 0;
    int           items_sent  = 0;
    int           longest_list = 0;
    int           status_seen [0:7];
    int           drain_guard;

    bounded_list_stack_queue_engine_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (cmd),
        .i_value_in     (value_in),
        .i_position_in  (position_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_value_out    (o_value_out),
        .o_position_out (o_position_out),
        .o_status       (o_status),
        .o_count_out    (o_count_out)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_list_result predict_list_command(
        input logic [CMD_W-1:0]    op,
        input logic [VAL_W-1:0]    val,
        input logic [POS_IN_W-1:0] pos
    );
        t_list_result r;
        logic [5:0]   s;
        logic [5:0]   p;
        logic         hit;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        case (op)
            CMD_PUSH_FRONT: begin
                if (shadow_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    s = shadow_free;
                    shadow_free = shadow_link[s];
                    shadow_value[s] = val;
                    shadow_link[s] = shadow_head;
                    shadow_head = s;
                    if (shadow_count == 0) shadow_tail = s;
                    shadow_count++;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s = shadow_head;
                    r.value = shadow_value[s];
                    shadow_head = shadow_link[s];
                    shadow_link[s] = shadow_free;
                    shadow_free = s;
                    shadow_count--;
                    if (shadow_count == 0) begin
                        shadow_head = '0;
                        shadow_tail = '0;
                    end
                end
            end
            CMD_PUSH_BACK: begin
                if (shadow_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    s = shadow_free;
                    shadow_free = shadow_link[s];
                    shadow_value[s] = val;
                    if (shadow_count == 0) shadow_head = s;
                    else shadow_link[shadow_tail] = s;
                    shadow_tail = s;
                    shadow_count++;
                end
            end
            CMD_INSERT_AFTER: begin
                if (shadow_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (pos == 0 || pos > shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    p = shadow_head;
                    for (int i = 1; i < pos; i++) p = shadow_link[p];
                    s = shadow_free;
                    shadow_free = shadow_link[s];
                    shadow_value[s] = val;
                    shadow_link[s] = shadow_link[p];
                    shadow_link[p] = s;
                    if (pos == shadow_count) shadow_tail = s;
                    shadow_count++;
                end
            end
            CMD_DELETE_LAST: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s = shadow_tail;
                    if (shadow_count >= 2) begin
                        p = shadow_head;
                        for (int i = 0; i < shadow_count - 2; i++) p = shadow_link[p];
                        shadow_tail = p;
                    end
                    shadow_link[s] = shadow_free;
                    shadow_free = s;
                    shadow_count--;
                    if (shadow_count == 0) begin
                        shadow_head = '0;
                        shadow_tail = '0;
                    end
                end
            end
            CMD_FIND: begin
                r.status = ST_NOTFOUND;
                s = shadow_head;
                for (int i = 0; i < shadow_count; i++) begin
                    if (!hit && shadow_value[s] == val) begin
                        hit = 1'b1;
                        r.position = 6'(i);
                        r.status = ST_OK;
                    end
                    s = shadow_link[s];
                end
            end
            default: begin
            end
        endcase
        r.count = 7'(shadow_count);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(6) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(
        input logic [CMD_W-1:0]    op,
        input logic [VAL_W-1:0]    val,
        input logic [POS_IN_W-1:0] pos
    );
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        value_in    <= val;
        position_in <= pos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(predict_list_command(op, val, pos));
        items_sent++;
    endtask

    always @(negedge i_clk) begin
        out_ready <= steady_flow || ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        if (o_out_valid && out_ready) begin
            got_result = '{o_value_out, o_position_out, o_status, o_count_out};
            status_seen[o_status]++;
            if (o_count_out > longest_list) longest_list = o_count_out;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected item, got value %0d pos %0d status %0d count %0d",
                         $realtime, got_result.value, got_result.position,
                         got_result.status, got_result.count);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result) begin
                    mismatches++;
                    $display("%0t ns: mismatch, expected value %0d pos %0d status %0d count %0d",
                             $realtime, want_result.value, want_result.position,
                             want_result.status, want_result.count);
                    $display("%0t ns:            got value %0d pos %0d status %0d count %0d",
                             $realtime, got_result.value, got_result.position,
                             got_result.status, got_result.count);
                end
            end
        end
    end

    task automatic test_empty_list();
        send_command(CMD_POP_FRONT, 32'd0, 7'd0);
        send_command(CMD_DELETE_LAST, 32'd5, 7'd1);
        send_command(CMD_FIND, 32'd0, 7'd0);
        send_command(CMD_INSERT_AFTER, 32'd9, 7'd1);
        send_command(CMD_UNUSED_SIX, 32'hFFFF_FFFF, 7'd127);
        send_command(CMD_UNUSED_SEVEN, 32'd1, 7'd64);
    endtask

    task automatic test_edge_values();
        send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 7'd0);
        send_command(CMD_PUSH_BACK, 32'h8000_0000, 7'd0);
        send_command(CMD_PUSH_FRONT, 32'd0, 7'd0);
        send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF, 7'd0);
        send_command(CMD_INSERT_AFTER, 32'd1, 7'd0);
        send_command(CMD_INSERT_AFTER, 32'd2, 7'd5);
        send_command(CMD_INSERT_AFTER, 32'd3, 7'd127);
        send_command(CMD_INSERT_AFTER, 32'h5555_5555, 7'd4);
        send_command(CMD_PUSH_BACK, 32'h7FFF_FFFF, 7'd0);
        send_command(CMD_INSERT_AFTER, 32'hAAAA_AAAA, 7'd1);
        send_command(CMD_FIND, 32'h8000_0000, 7'd0);
        send_command(CMD_FIND, 32'h7FFF_FFFF, 7'd0);
        send_command(CMD_FIND, 32'h5555_5555, 7'd0);
        send_command(CMD_FIND, 32'd12345, 7'd0);
        send_command(CMD_UNUSED_SIX, 32'd0, 7'd0);
    endtask

    task automatic test_drain_to_empty();
        while (shadow_count > 0) begin
            send_command(shadow_count[0] ? CMD_DELETE_LAST : CMD_POP_FRONT, 32'd0, 7'd0);
        end
    endtask

    task automatic test_random_traffic(input int total);
        int               mode;
        int               r;
        int               k;
        logic [CMD_W-1:0] op;
        logic [VAL_W-1:0] val;
        logic [POS_IN_W-1:0] pos;
        logic [5:0]       s;
        for (int n = 0; n < total; n++) begin
            mode = (n / 250) % 4;
            steady_flow = (n / 250 == 2);
            r = $urandom_range(99);
            case (mode)
                0: op = r < 25 ? CMD_PUSH_FRONT : r < 50 ? CMD_PUSH_BACK :
                        r < 75 ? CMD_INSERT_AFTER : r < 82 ? CMD_POP_FRONT :
                        r < 88 ? CMD_DELETE_LAST : r < 97 ? CMD_FIND :
                        r[0] ? CMD_UNUSED_SIX : CMD_UNUSED_SEVEN;
                1: op = r < 10 ? CMD_PUSH_FRONT : r < 20 ? CMD_PUSH_BACK :
                        r < 30 ? CMD_INSERT_AFTER : r < 60 ? CMD_POP_FRONT :
                        r < 85 ? CMD_DELETE_LAST : r < 97 ? CMD_FIND :
                        r[0] ? CMD_UNUSED_SIX : CMD_UNUSED_SEVEN;
                2: op = r < 17 ? CMD_PUSH_FRONT : r < 34 ? CMD_PUSH_BACK :
                        r < 50 ? CMD_INSERT_AFTER : r < 66 ? CMD_POP_FRONT :
                        r < 82 ? CMD_DELETE_LAST : r < 97 ? CMD_FIND :
                        r[0] ? CMD_UNUSED_SIX : CMD_UNUSED_SEVEN;
                default: op = r < 15 ? CMD_PUSH_FRONT : r < 25 ? CMD_PUSH_BACK :
                        r < 35 ? CMD_INSERT_AFTER : r < 42 ? CMD_POP_FRONT :
                        r < 52 ? CMD_DELETE_LAST : r < 97 ? CMD_FIND :
                        r[0] ? CMD_UNUSED_SIX : CMD_UNUSED_SEVEN;
            endcase
            val = pick_value();
            if (op == CMD_FIND && shadow_count > 0 && $urandom_range(99) < 60) begin
                k = $urandom_range(shadow_count - 1);
                s = shadow_head;
                repeat (k) s = shadow_link[s];
                val = shadow_value[s];
            end
            r = $urandom_range(99);
            if (r < 80 && shadow_count > 0) pos = 7'($urandom_range(shadow_count, 1));
            else if (r < 90) pos = r[0] ? 7'(shadow_count + 1) : 7'd0;
            else pos = 7'($urandom_range(127));
            send_command(op, val, pos);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        cmd         = '0;
        value_in    = '0;
        position_in = '0;
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        for (int i = 0; i < LIST_DEPTH; i++) shadow_link[i] = 6'(i + 1);
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_free  = '0;
        shadow_count = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edge_values();
        test_drain_to_empty();
        test_random_traffic(1750);

        @(negedge i_clk);
        in_valid <= 1'b0;
        drain_guard = 0;
        while (pending_results.size() != 0 && drain_guard < 20000) begin
            @(posedge i_clk);
            drain_guard++;
        end
        repeat (80) @(posedge i_clk);
        mismatches += pending_results.size();
        $display("Covered %0d commands, longest list %0d entries", items_sent, longest_list);
        $display("Statuses ok/empty/full/bad position/not found: %0d/%0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_BADPOS], status_seen[ST_NOTFOUND]);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/blsq_pkg.sv
sv/blsq_ram.sv
sv/bounded_list_stack_queue_engine_core.sv
tb/tb_top.sv
